[rtl/core/ssq_pkg.sv]
`default_nettype none
package ssq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRIO_BITS = 8;
  localparam int TAG_BITS = 16;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ssq_cmd_t;

endpackage
`default_nettype wire

[rtl/core/ssq_ctrl.sv]
`default_nettype none
module ssq_ctrl
  import ssq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output ssq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: state_next = S_RESP;
      S_RESP: begin
        // A new beat may be taken while the previous result is shown.
        if (start) state_next = S_EXEC;
        else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state == S_EXEC);
  assign done = (state == S_RESP);
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == S_EXEC);

endmodule
`default_nettype wire

[rtl/core/ssq_datapath.sv]
`default_nettype none
module ssq_datapath
  import ssq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ssq_cmd_t              cmd,
  input  wire logic                  opcode,
  input  wire logic [PRIO_BITS-1:0]  entry_priority,
  input  wire logic [TAG_BITS-1:0]   entry_tag,
  output logic [1:0]                 status,
  output logic [PRIO_BITS-1:0]       popped_priority,
  output logic [TAG_BITS-1:0]        popped_tag,
  output logic [PRIO_BITS-1:0]       head_priority,
  output logic [TAG_BITS-1:0]        head_tag,
  output logic [COUNT_BITS-1:0]      occupancy,
  output logic                       is_empty,
  output logic                       is_full
);

  logic                  op_q;
  logic [PRIO_BITS-1:0]  prio_q;
  logic [TAG_BITS-1:0]   tag_q;

  logic [PRIO_BITS-1:0]  slot_pri [CAPACITY];
  logic [TAG_BITS-1:0]   slot_tag [CAPACITY];
  logic [PRIO_BITS-1:0]  slot_pri_next [CAPACITY];
  logic [TAG_BITS-1:0]   slot_tag_next [CAPACITY];
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [CAPACITY-1:0]   stays;

  logic [1:0]            status_next;
  logic [PRIO_BITS-1:0]  popped_pri_next;
  logic [TAG_BITS-1:0]   popped_tag_next;
  logic                  cnt_empty;
  logic                  cnt_full;

  assign cnt_empty = (count == '0);
  assign cnt_full = (count == COUNT_BITS'(CAPACITY));

  // An occupied slot whose priority is not above the new one keeps its place,
  // which puts the new entry behind all entries of equal priority.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      stays[i] = (count > COUNT_BITS'(i)) && (slot_pri[i] <= prio_q);
    end
  end

  always_comb begin
    status_next = STATUS_OK;
    popped_pri_next = '0;
    popped_tag_next = '0;
    count_next = count;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_pri_next[i] = slot_pri[i];
      slot_tag_next[i] = slot_tag[i];
    end
    if (op_q == OP_INSERT) begin
      if (cnt_full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + COUNT_BITS'(1);
        if (!stays[0]) begin
          slot_pri_next[0] = prio_q;
          slot_tag_next[0] = tag_q;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (!stays[i]) begin
            if (stays[i-1]) begin
              slot_pri_next[i] = prio_q;
              slot_tag_next[i] = tag_q;
            end else begin
              slot_pri_next[i] = slot_pri[i-1];
              slot_tag_next[i] = slot_tag[i-1];
            end
          end
        end
      end
    end else begin
      if (cnt_empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        popped_pri_next = slot_pri[0];
        popped_tag_next = slot_tag[0];
        count_next = count - COUNT_BITS'(1);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          slot_pri_next[i] = slot_pri[i+1];
          slot_tag_next[i] = slot_tag[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= opcode;
      prio_q <= entry_priority;
      tag_q <= entry_tag;
    end
    if (cmd.exec) begin
      status <= status_next;
      popped_priority <= popped_pri_next;
      popped_tag <= popped_tag_next;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_pri[i] <= slot_pri_next[i];
        slot_tag[i] <= slot_tag_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.exec) count <= count_next;
  end

  assign head_priority = cnt_empty ? '0 : slot_pri[0];
  assign head_tag = cnt_empty ? '0 : slot_tag[0];
  assign occupancy = count;
  assign is_empty = cnt_empty;
  assign is_full = cnt_full;

endmodule
`default_nettype wire

[rtl/core/stable_sorted_priority_queue.sv]
// Stable sorted priority queue of up to 16 entries, lower priority value first.
// Command channel: an item (opcode, entry_priority, entry_tag) is taken at a
// rising edge with start high and busy low. Opcode 0 inserts the entry behind
// all stored entries of equal priority; opcode 1 pops the head entry.
// Result channel: done is high for exactly one cycle per item and carries the
// status, the popped entry, the new head entry, occupancy and the empty/full
// flags. The receiver cannot stall; each result is shown for one cycle only.
// Latency: an item taken at edge k shows its result in the cycle after edge
// k+1, and the result beat ends at edge k+2. Busy is high during the one execute
// cycle; a new item may be taken while the previous result is shown, so the
// block sustains one item every 2 cycles, set by the input register followed
// by one cycle of parallel compare and shift across the slot array.
// Reset clears the entry count, so the queue starts empty; the slots themselves
// are not cleared, since only occupied slots are ever read.
`default_nettype none
module stable_sorted_priority_queue
  import ssq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  opcode,
  input  wire logic [PRIO_BITS-1:0]  entry_priority,
  input  wire logic [TAG_BITS-1:0]   entry_tag,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [PRIO_BITS-1:0]       popped_priority,
  output logic [TAG_BITS-1:0]        popped_tag,
  output logic [PRIO_BITS-1:0]       head_priority,
  output logic [TAG_BITS-1:0]        head_tag,
  output logic [COUNT_BITS-1:0]      occupancy,
  output logic                       is_empty,
  output logic                       is_full
);

  ssq_cmd_t cmd;

  ssq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ssq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .opcode          (opcode),
    .entry_priority  (entry_priority),
    .entry_tag       (entry_tag),
    .status          (status),
    .popped_priority (popped_priority),
    .popped_tag      (popped_tag),
    .head_priority   (head_priority),
    .head_tag        (head_tag),
    .occupancy       (occupancy),
    .is_empty        (is_empty),
    .is_full         (is_full)
  );

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not enter execute");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= COUNT_BITS'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_reject_no_pop: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (popped_priority == '0 && popped_tag == '0))
    else $error("rejected beat reports a popped entry");

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ssq_pkg::*;

  typedef struct packed {
    logic [1:0]            status;
    logic [PRIO_BITS-1:0]  popped_priority;
    logic [TAG_BITS-1:0]   popped_tag;
    logic [PRIO_BITS-1:0]  head_priority;
    logic [TAG_BITS-1:0]   head_tag;
    logic [COUNT_BITS-1:0] occupancy;
    logic                  is_empty;
    logic                  is_full;
  } queue_result_t;

  localparam int STALL_LIMIT = 500;
  localparam int TAIL_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  opcode = OP_INSERT;
  logic [PRIO_BITS-1:0]  entry_priority = '0;
  logic [TAG_BITS-1:0]   entry_tag = '0;
  logic                  busy;
  logic                  done;
  logic [1:0]            status;
  logic [PRIO_BITS-1:0]  popped_priority;
  logic [TAG_BITS-1:0]   popped_tag;
  logic [PRIO_BITS-1:0]  head_priority;
  logic [TAG_BITS-1:0]   head_tag;
  logic [COUNT_BITS-1:0] occupancy;
  logic                  is_empty;
  logic                  is_full;

  // Shadow copy of the sorted slot array, head at index 0.
  logic [PRIO_BITS-1:0]  shadow_prio [CAPACITY];
  logic [TAG_BITS-1:0]   shadow_tag [CAPACITY];
  int                    shadow_count = 0;

  queue_result_t         pending_results [$];
  int                    mismatches = 0;
  int                    stall_cycles = 0;

  stable_sorted_priority_queue DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .entry_priority  (entry_priority),
    .entry_tag       (entry_tag),
    .done            (done),
    .status          (status),
    .popped_priority (popped_priority),
    .popped_tag      (popped_tag),
    .head_priority   (head_priority),
    .head_tag        (head_tag),
    .occupancy       (occupancy),
    .is_empty        (is_empty),
    .is_full         (is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_queue_result(input logic op, input logic [PRIO_BITS-1:0] pr,
                                      input logic [TAG_BITS-1:0] tg,
                                      output queue_result_t r);
    int pos;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        // Equal priorities go behind the stored ones, so ties leave in arrival order.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= pr) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_tag[i] = shadow_tag[i-1];
        end
        shadow_prio[pos] = pr;
        shadow_tag[pos] = tg;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.popped_priority = shadow_prio[0];
        r.popped_tag = shadow_tag[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_tag[i-1] = shadow_tag[i];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      r.head_priority = shadow_prio[0];
      r.head_tag = shadow_tag[0];
    end
    r.occupancy = shadow_count[COUNT_BITS-1:0];
    r.is_empty = (shadow_count == 0);
    r.is_full = (shadow_count == CAPACITY);
  endtask

  // Holds one command until the block takes it, then records its expected result.
  task automatic send_item(input logic op, input logic [PRIO_BITS-1:0] pr,
                           input logic [TAG_BITS-1:0] tg);
    queue_result_t r;
    start <= 1'b1;
    opcode <= op;
    entry_priority <= pr;
    entry_tag <= tg;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_result(op, pr, tg, r);
    pending_results.push_back(r);
  endtask

  // Drops start for a number of cycles; the fields carry noise meanwhile.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      opcode <= 1'($urandom);
      entry_priority <= PRIO_BITS'($urandom);
      entry_tag <= TAG_BITS'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("popped_priority", 32'(want.popped_priority), 32'(popped_priority));
        check_field("popped_tag", 32'(want.popped_tag), 32'(popped_tag));
        check_field("head_priority", 32'(want.head_priority), 32'(head_priority));
        check_field("head_tag", 32'(want.head_tag), 32'(head_tag));
        check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
        check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
        check_field("is_full", 32'(want.is_full), 32'(is_full));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_item(OP_POP, 8'h00, 16'h0000);
    send_item(OP_INSERT, 8'hFF, 16'hFFFF);
    send_item(OP_INSERT, 8'h00, 16'h0000);
    send_item(OP_INSERT, 8'h80, 16'h0A01);
    idle_cycles(1);
    send_item(OP_INSERT, 8'h80, 16'h0A02);
    send_item(OP_INSERT, 8'h80, 16'h0A03);
    send_item(OP_INSERT, 8'h00, 16'h5555);
    send_item(OP_INSERT, 8'hFF, 16'hAAAA);
    // Fill the rest of the slots so the next insert hits a full queue.
    for (int i = 0; i < 9; i++)
      send_item(OP_INSERT, PRIO_BITS'(8'h40 + 8'(i % 3)), TAG_BITS'(16'hC000 + i));
    send_item(OP_INSERT, 8'h00, 16'hDEAD);
    idle_cycles(3);
    send_item(OP_POP, 8'hFF, 16'hFFFF);
    send_item(OP_POP, 8'h00, 16'h0000);
    send_item(OP_POP, 8'h12, 16'h3456);
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int count);
    int sent;
    int burst;
    int insert_pct;
    logic op;
    logic [PRIO_BITS-1:0] pr;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      for (int i = 0; i < burst && sent < count; i++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
        case ($urandom_range(0, 3))
          0: pr = PRIO_BITS'($urandom_range(0, 3));
          1: pr = $urandom_range(0, 1) ? '1 : '0;
          default: pr = PRIO_BITS'($urandom);
        endcase
        send_item(op, pr, TAG_BITS'($urandom));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(470);
    wait_for_drain();
    test_random_mix(460);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[stable_sorted_priority_queue.f]
rtl/core/ssq_pkg.sv
rtl/core/ssq_ctrl.sv
rtl/core/ssq_datapath.sv
rtl/core/stable_sorted_priority_queue.sv
test/tb.sv
